FILE: hdl/lbvh_split_search_core_assert.svh
// Assertion macros shared by the checker of the split search core.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef LBVH_SPLIT_SEARCH_CORE_ASSERT_SVH
`define LBVH_SPLIT_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LBVH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LBVH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lbvh_pkg.sv
package lbvh_pkg;

  // Number of code store entries and the derived store address width.
  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);

  // Field widths of the item interface.
  localparam int IDX_W  = 10;
  localparam int CODE_W = 32;

  // Operation codes of an input beat.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write_en;      // store the code of the accepted write beat
    logic accept_query;  // latch the range and read the first code
    logic latch_first;   // keep the first code and read the last code
    logic start_search;  // build the prefix mask and read the first probe
    logic do_step;       // judge the current probe and read the next one
    logic emit_err;      // present a reversed-range result
    logic emit_mid;      // present the midpoint of the range
    logic emit_split;    // present the search result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_bad;     // first index exceeds last index
    logic codes_equal;   // codes at both ends of the range match
    logic last_step;     // the probe being judged is the final one
  } sts_t;

endpackage

FILE: hdl/lbvh_ctrl.sv
module lbvh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_operation,
  input  lbvh_pkg::sts_t sts,
  output lbvh_pkg::cmd_t cmd,
  output logic          busy
);
  import lbvh_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIRST = 2'd1;
  localparam logic [1:0] S_LAST  = 2'd2;
  localparam logic [1:0] S_STEP  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_QUERY) begin
            cmd.accept_query = 1'b1;
            state_nxt        = S_FIRST;
          end else begin
            cmd.write_en = 1'b1;
          end
        end
      end
      S_FIRST: begin
        if (sts.range_bad) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.latch_first = 1'b1;
          state_nxt       = S_LAST;
        end
      end
      S_LAST: begin
        if (sts.codes_equal) begin
          cmd.emit_mid = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.start_search = 1'b1;
          state_nxt        = S_STEP;
        end
      end
      S_STEP: begin
        cmd.do_step = 1'b1;
        if (sts.last_step) begin
          cmd.emit_split = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: hdl/lbvh_dpath.sv
module lbvh_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbvh_pkg::cmd_t                cmd,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [lbvh_pkg::CODE_W-1:0]   in_code_value,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_first_index,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_last_index,
  output lbvh_pkg::sts_t                sts,
  output logic                          out_valid,
  output logic [lbvh_pkg::IDX_W-1:0]    out_split_index,
  output logic                          out_range_error
);
  import lbvh_pkg::*;

  logic [CODE_W-1:0] mem [ENTRIES];

  logic [IDX_W-1:0]  first_r;
  logic [IDX_W-1:0]  last_r;
  logic [CODE_W-1:0] first_code_r;
  logic [CODE_W-1:0] mask_r;
  logic [IDX_W-1:0]  split_r;
  logic [IDX_W-1:0]  step_r;
  logic [IDX_W:0]    probe_r;
  logic [CODE_W-1:0] rd_data_r;
  logic              rd_oor_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  out_split_r;
  logic              out_err_r;

  logic [CODE_W-1:0] rd_code;
  logic [CODE_W-1:0] diff_code;
  logic [CODE_W-1:0] smear;
  logic [IDX_W-1:0]  span;
  logic [IDX_W-1:0]  step0;
  logic [IDX_W:0]    probe0;
  logic              hit;
  logic [IDX_W-1:0]  split_new;
  logic [IDX_W-1:0]  step_n;
  logic [IDX_W:0]    probe_n;
  logic [IDX_W:0]    rd_idx;
  logic              rd_oor;
  logic              wr_ok;
  logic [IDX_W:0]    mid_sum;

  // Entries at or beyond the store size read as zero.
  assign rd_code   = rd_oor_r ? '0 : rd_data_r;
  assign diff_code = first_code_r ^ rd_code;

  // Fill every bit below the highest differing bit; the mask then covers the
  // common prefix plus one bit.
  always_comb begin
    smear = diff_code;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
  end

  assign span   = last_r - first_r;
  assign step0  = IDX_W'(({1'b0, span} + (IDX_W+1)'(1)) >> 1);
  assign probe0 = {1'b0, first_r} + {1'b0, step0};

  // A probe counts when it lies below last and shares more than the prefix.
  assign hit       = (probe_r < {1'b0, last_r}) && ((diff_code & mask_r) == '0);
  assign split_new = hit ? probe_r[IDX_W-1:0] : split_r;
  assign step_n    = IDX_W'(({1'b0, step_r} + (IDX_W+1)'(1)) >> 1);
  assign probe_n   = {1'b0, split_new} + {1'b0, step_n};

  assign mid_sum = {1'b0, first_r} + {1'b0, last_r};

  always_comb begin
    rd_idx = {1'b0, in_first_index};
    if (cmd.latch_first) begin
      rd_idx = {1'b0, last_r};
    end else if (cmd.start_search) begin
      rd_idx = probe0;
    end else if (cmd.do_step) begin
      rd_idx = probe_n;
    end
  end

  assign rd_oor = (32'(rd_idx) >= 32'(ENTRIES));
  assign wr_ok  = cmd.write_en && (32'(in_entry_index) < 32'(ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[ADDR_W'(in_entry_index)] <= in_code_value;
    end
    rd_data_r <= mem[ADDR_W'(rd_idx)];
    rd_oor_r  <= rd_oor;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_query) begin
      first_r <= in_first_index;
      last_r  <= in_last_index;
    end
    if (cmd.latch_first) begin
      first_code_r <= rd_code;
    end
    if (cmd.start_search) begin
      mask_r  <= ~(smear >> 1);
      split_r <= first_r;
      step_r  <= step0;
      probe_r <= probe0;
    end
    if (cmd.do_step) begin
      split_r <= split_new;
      step_r  <= step_n;
      probe_r <= probe_n;
    end
    if (cmd.emit_err) begin
      out_split_r <= '0;
      out_err_r   <= 1'b1;
    end else if (cmd.emit_mid) begin
      out_split_r <= mid_sum[IDX_W:1];
      out_err_r   <= 1'b0;
    end else if (cmd.emit_split) begin
      out_split_r <= split_new;
      out_err_r   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_err || cmd.emit_mid || cmd.emit_split;
    end
  end

  assign sts.range_bad   = (first_r > last_r);
  assign sts.codes_equal = (diff_code == '0);
  assign sts.last_step   = (step_r <= IDX_W'(1));

  assign out_valid       = out_valid_r;
  assign out_split_index = out_split_r;
  assign out_range_error = out_err_r;

endmodule

FILE: hdl/lbvh_split_search_core.sv
// Channel   Ports                                     Beat taken when
// -------   ----------------------------------------  --------------------------
// input     in_operation, in_entry_index,             start high, busy low
//           in_code_value, in_first_index,
//           in_last_index
// result    out_split_index, out_range_error          out_valid high (one cycle)
//
// A write beat leaves busy low, so beats may follow back to back. A query
// keeps busy high until the controller returns to idle: after the first-code
// read on a reversed range, after the last-code read when the end codes match,
// and otherwise after the search loop, which takes one step per halving that
// brings last_index - first_index down to one (ceil(log2(span)) steps, at least 1).
// The search is paced by the single registered read port of the code store:
// each search step needs the code of the probe chosen by the step before.
// The result is on the ports in the cycle in which busy falls; the receiver
// cannot stall it, and a new beat may be taken in that same cycle.
// rst_n is synchronous and active low; it clears the controller state and
// the result strobe, while the store keeps its contents undefined until
// written.
module lbvh_split_search_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [lbvh_pkg::CODE_W-1:0]   in_code_value,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_first_index,
  input  logic [lbvh_pkg::IDX_W-1:0]    in_last_index,
  output logic                          out_valid,
  output logic [lbvh_pkg::IDX_W-1:0]    out_split_index,
  output logic                          out_range_error
);
  import lbvh_pkg::*;

  // The controller sequences a query through four states: idle, read of
  // the first code, read of the last code, and the halving search loop.
  // The datapath owns the code store, the range and search registers and
  // the result register.
  cmd_t cmd;
  sts_t sts;

  lbvh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  // The common prefix is kept as a mask over the top bits rather than as a
  // count: a probe shares a longer prefix exactly when its difference from
  // the first code is zero under that mask.
  lbvh_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_entry_index  (in_entry_index),
    .in_code_value   (in_code_value),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_split_index (out_split_index),
    .out_range_error (out_range_error)
  );

endmodule

FILE: hdl/lbvh_split_search_core_checker.sv
module lbvh_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_operation,
  input logic [lbvh_pkg::IDX_W-1:0] in_first_index,
  input logic [lbvh_pkg::IDX_W-1:0] in_last_index,
  input logic                       out_valid,
  input logic [lbvh_pkg::IDX_W-1:0] out_split_index,
  input logic                       out_range_error
);
  import lbvh_pkg::*;
  `include "lbvh_split_search_core_assert.svh"

  `LBVH_ASSERT_NEXT(a_write_no_busy, start && !busy && (in_operation == OP_WRITE), !busy, "write beat made the core busy")
  `LBVH_ASSERT_NEXT(a_query_busy, start && !busy && (in_operation == OP_QUERY), busy, "query beat did not make the core busy")
  `LBVH_ASSERT_SAME(a_result_idle, out_valid, !busy, "result shown while a query is still running")
  `LBVH_ASSERT_SAME(a_err_zero, out_valid && out_range_error, out_split_index == '0, "error result with nonzero split")
  `LBVH_ASSERT_SAME(a_reversed, start && !busy && (in_operation == OP_QUERY) && (in_first_index > in_last_index), ##2 (out_valid && out_range_error), "reversed range not flagged two cycles later")

endmodule

bind lbvh_split_search_core lbvh_checker u_lbvh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .in_first_index  (in_first_index),
  .in_last_index   (in_last_index),
  .out_valid       (out_valid),
  .out_split_index (out_split_index),
  .out_range_error (out_range_error)
);

FILE: tb/sv/tb_lbvh_split_search_core.sv
module tb_lbvh_split_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lbvh_pkg::*;

  // Roughly how many beats the whole run sends, directed part included.
  localparam int BEAT_TARGET  = 1850;
  // Drain length; it outlasts the longest busy stretch of a query and the
  // result that follows it, so it covers any result still in flight.
  localparam int DRAIN_CYCLES = 40;
  // Slowest correct beat: the longest gap, the longest busy stretch of a
  // query and its result. The watchdog allows around 2100 beats at that
  // pace several times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int GAP_MAX      = 12;

  // One beat of the input channel. Fields that the operation does not use
  // still carry random values so that every port bit toggles.
  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  entry;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
  } store_beat_t;

  // One expected result of a query.
  typedef struct {
    logic [IDX_W-1:0] split_index;
    logic             range_error;
  } split_answer_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [IDX_W-1:0]  in_entry_index;
  logic [CODE_W-1:0] in_code_value;
  logic [IDX_W-1:0]  in_first_index;
  logic [IDX_W-1:0]  in_last_index;
  logic              out_valid;
  logic [IDX_W-1:0]  out_split_index;
  logic              out_range_error;

  lbvh_split_search_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_entry_index  (in_entry_index),
    .in_code_value   (in_code_value),
    .in_first_index  (in_first_index),
    .in_last_index   (in_last_index),
    .out_valid       (out_valid),
    .out_split_index (out_split_index),
    .out_range_error (out_range_error)
  );

  // Beats waiting to be sent, in order, and the answers still owed by the
  // block for queries it has already taken.
  store_beat_t   pending_beats[$];
  split_answer_t split_expect_q[$];

  // The generator's view of which store entries hold a code. Queries in order
  // are only built over ranges that are fully written, since an entry read
  // before its first write has no defined value.
  bit written_map [ENTRIES];

  // The predictor's own copy of the code store, updated as write beats are
  // taken by the block.
  logic [CODE_W-1:0] code_mirror [ENTRIES];

  int          beats_sent;
  int          beats_taken;
  int          gap_left;
  bit          no_idle;
  int          fail_count;
  int          cycle_count;
  store_beat_t drv_beat;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Leading-zero count of a 32-bit word; an all-zero word counts 32.
  function automatic int lead_zero_count(input logic [CODE_W-1:0] word);
    int n;
    n = 0;
    for (int b = CODE_W - 1; b >= 0; b--) begin
      if (word[b[4:0]]) begin
        return n;
      end
      n++;
    end
    return n;
  endfunction

  // Split of the range [lo, hi] over the mirrored store. A reversed range
  // flags an error; matching end codes give the rounded-down midpoint;
  // otherwise halving steps walk toward the highest index below hi whose
  // code shares a longer prefix with the first code than the end codes do.
  function automatic split_answer_t predict_split(input logic [IDX_W-1:0] lo,
                                                  input logic [IDX_W-1:0] hi);
    split_answer_t ans;
    logic [CODE_W-1:0] lo_code;
    logic [CODE_W-1:0] hi_code;
    int lo_i;
    int hi_i;
    int common;
    int split;
    int step;
    int probe;
    lo_i = int'(lo);
    hi_i = int'(hi);
    ans.split_index = '0;
    ans.range_error = 1'b0;
    if (lo_i > hi_i) begin
      ans.range_error = 1'b1;
      return ans;
    end
    lo_code = code_mirror[lo];
    hi_code = code_mirror[hi];
    if (lo_code == hi_code) begin
      ans.split_index = IDX_W'((lo_i + hi_i) >> 1);
      return ans;
    end
    common = lead_zero_count(lo_code ^ hi_code);
    split = lo_i;
    step = hi_i - lo_i;
    do begin
      step = (step + 1) >> 1;
      probe = split + step;
      if (probe < hi_i) begin
        if (lead_zero_count(lo_code ^ code_mirror[ADDR_W'(probe)]) > common) begin
          split = probe;
        end
      end
    end while (step > 1);
    ans.split_index = IDX_W'(split);
    return ans;
  endfunction

  task automatic push_write(input int idx, input logic [CODE_W-1:0] code);
    store_beat_t b;
    b.op = OP_WRITE;
    b.entry = IDX_W'(idx);
    b.code = code;
    b.lo = IDX_W'($urandom_range(0, ENTRIES - 1));
    b.hi = IDX_W'($urandom_range(0, ENTRIES - 1));
    pending_beats.push_back(b);
    written_map[ADDR_W'(idx)] = 1'b1;
  endtask

  task automatic push_query(input int lo, input int hi);
    store_beat_t b;
    b.op = OP_QUERY;
    b.entry = IDX_W'($urandom_range(0, ENTRIES - 1));
    b.code = $urandom;
    b.lo = IDX_W'(lo);
    b.hi = IDX_W'(hi);
    pending_beats.push_back(b);
  endtask

  // The well-formed case: a contiguous run of ascending Morton codes, with
  // duplicates, written at a random spot, then a few queries inside it.
  // Most runs are short so that each query stays cheap; now and then a
  // longer run gives the search more halving steps.
  task automatic add_sorted_run();
    int size;
    int base;
    int nq;
    int lo;
    int hi;
    int tmp;
    logic [CODE_W:0] acc;
    size = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 160) : $urandom_range(2, 24);
    base = $urandom_range(0, ENTRIES - size);
    acc = {1'b0, $urandom >> $urandom_range(0, 31)};
    for (int k = 0; k < size; k++) begin
      if ($urandom_range(0, 4) != 0) begin
        acc = acc + {1'b0, ($urandom >> $urandom_range(4, 31))};
      end
      // Saturate instead of wrapping so the run stays sorted.
      if (acc[CODE_W]) begin
        acc = {1'b0, {CODE_W{1'b1}}};
      end
      push_write(base + k, acc[CODE_W-1:0]);
    end
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 2) == 0) begin
        lo = base;
        hi = base + size - 1;
      end else begin
        lo = base + $urandom_range(0, size - 1);
        hi = base + $urandom_range(0, size - 1);
        // Keep most of them in order; the rest test the reversed-range flag.
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
      push_query(lo, hi);
    end
  endtask

  // Noise: unsorted writes anywhere, reversed ranges of any span, and
  // queries over whatever written stretch happens to start at a random spot.
  task automatic add_noise();
    int lo;
    int hi;
    int cap;
    case ($urandom_range(0, 2))
      0: begin
        push_write($urandom_range(0, ENTRIES - 1), $urandom);
      end
      1: begin
        lo = $urandom_range(1, ENTRIES - 1);
        hi = $urandom_range(0, lo - 1);
        push_query(lo, hi);
      end
      default: begin
        lo = $urandom_range(0, ENTRIES - 1);
        if (!written_map[ADDR_W'(lo)]) begin
          push_write(lo, $urandom);
        end else begin
          cap = ($urandom_range(0, 3) == 0) ? ENTRIES : $urandom_range(0, 40);
          hi = lo;
          while (hi < ENTRIES - 1 && written_map[ADDR_W'(hi + 1)] && hi - lo < cap) begin
            hi++;
          end
          push_query(lo, hi);
        end
      end
    endcase
  endtask

  // Driver. Inputs change only at the falling edge. A beat stays on the
  // ports until a rising edge sees start high and busy low; the monitor
  // counts those edges in beats_taken, so the current beat is gone once
  // that count has caught up with beats_sent. Each beat draws the gap that
  // follows it, and now and then the driver switches into or out of a
  // stretch with no gaps at all. When the next beat follows without a gap,
  // start simply stays high.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beats_taken == beats_sent) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left = gap_left - 1;
      end else if (pending_beats.size() > 0) begin
        drv_beat = pending_beats.pop_front();
        in_operation   <= drv_beat.op;
        in_entry_index <= drv_beat.entry;
        in_code_value  <= drv_beat.code;
        in_first_index <= drv_beat.lo;
        in_last_index  <= drv_beat.hi;
        start          <= 1'b1;
        beats_sent = beats_sent + 1;
        if ($urandom_range(0, 39) == 0) begin
          no_idle = !no_idle;
        end
        gap_left = no_idle ? 0 : $urandom_range(0, GAP_MAX);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor and predictor. At each rising edge it first checks a result
  // that ends its one-cycle window here, then takes note of a beat the
  // block accepts at the same edge. Checking first keeps a new query's
  // expectation from ever being matched against an older result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (split_expect_q.size() == 0) begin
          $display("%0t: result with no query outstanding, actual split %0d error %0b",
                   $time, out_split_index, out_range_error);
          fail_count = fail_count + 1;
        end else begin
          if (out_split_index !== split_expect_q[0].split_index) begin
            $display("%0t: split_index mismatch, expected %0d, actual %0d",
                     $time, split_expect_q[0].split_index, out_split_index);
            fail_count = fail_count + 1;
          end
          if (out_range_error !== split_expect_q[0].range_error) begin
            $display("%0t: range_error mismatch, expected %0b, actual %0b",
                     $time, split_expect_q[0].range_error, out_range_error);
            fail_count = fail_count + 1;
          end
          void'(split_expect_q.pop_front());
        end
      end
      if (start && !busy) begin
        beats_taken <= beats_taken + 1;
        if (in_operation == OP_WRITE) begin
          code_mirror[in_entry_index] = in_code_value;
        end else begin
          split_expect_q.push_back(predict_split(in_first_index, in_last_index));
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_WRITE;
    in_entry_index = '0;
    in_code_value  = '0;
    in_first_index = '0;
    in_last_index  = '0;
    beats_sent     = 0;
    beats_taken    = 0;
    gap_left       = 0;
    no_idle        = 1'b0;
    fail_count     = 0;

    // Directed part. A small sorted block at the bottom of the store with
    // duplicates at both ends, then the top entries of the store.
    push_write(0, 32'h0000_0000);
    push_write(1, 32'h0000_0000);
    push_write(2, 32'h1234_5678);
    push_write(3, 32'h8000_0000);
    push_write(4, 32'hFFFF_FFFF);
    push_write(5, 32'hFFFF_FFFF);
    // A single-entry range and a pair of equal codes give the midpoint.
    push_query(0, 0);
    push_query(0, 1);
    // Widest code difference; in the 0..2 query a probe lands on a code equal to the first one,
    // whose XOR is zero and counts as the longest possible prefix.
    push_query(0, 4);
    push_query(0, 2);
    push_query(1, 3);
    push_query(0, 5);
    push_query(4, 5);
    push_query(3, 5);
    // Reversed ranges: by a wide margin, by one, and the full extremes.
    push_query(4, 0);
    push_query(5, 4);
    push_query(ENTRIES - 1, 0);
    push_write(ENTRIES - 3, 32'h8000_0000);
    push_write(ENTRIES - 2, 32'hFFFF_FFFE);
    push_write(ENTRIES - 1, 32'hFFFF_FFFF);
    push_query(ENTRIES - 3, ENTRIES - 1);
    push_query(ENTRIES - 2, ENTRIES - 1);
    push_query(ENTRIES - 1, ENTRIES - 1);

    // Random part: mostly sorted runs with queries inside them, the rest
    // noise.
    while (pending_beats.size() < BEAT_TARGET) begin
      if ($urandom_range(0, 9) < 7) begin
        add_sorted_run();
      end else begin
        add_noise();
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every beat to be taken, then for every owed answer, then a
    // short drain so a stray extra result would still be caught.
    while (pending_beats.size() > 0 || beats_taken != beats_sent) begin
      @(posedge clk);
    end
    while (split_expect_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (split_expect_q.size() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, split_expect_q.size());
      fail_count = fail_count + 1;
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/lbvh_pkg.sv
hdl/lbvh_ctrl.sv
hdl/lbvh_dpath.sv
hdl/lbvh_split_search_core.sv
hdl/lbvh_split_search_core_checker.sv
tb/sv/tb_lbvh_split_search_core.sv
